### design/asd_pkg.sv
// Shared types and constants of the accelerometer step detector.
package asd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int AXIS_W    = 16;
    localparam int MAG_W     = 16;
    localparam int LEVEL_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALLEY = 2'd2;

    localparam logic [15:0]        NOISE_RESET  = 16'd492;
    localparam logic [15:0]        PEAK_RESET   = 16'd4915;
    localparam logic signed [16:0] VALLEY_RESET = -17'sd492;

    localparam logic [1:0] TREND_FALL = 2'd0;
    localparam logic [1:0] TREND_RISE = 2'd1;
    localparam logic [1:0] TREND_NONE = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic signed [AXIS_W-1:0]  accel_x;
        logic signed [AXIS_W-1:0]  accel_y;
        logic signed [AXIS_W-1:0]  accel_z;
    } smp_item_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] relative_magnitude;
        logic                      sample_accepted;
        logic                      step_detected;
        logic [15:0]               step_total;
        logic [15:0]               last_peak;
    } res_item_t;

    typedef struct packed {
        logic [15:0]               noise_threshold;
        logic [15:0]               peak_threshold;
        logic signed [LEVEL_W-1:0] valley_threshold;
    } cfg_t;

endpackage

### design/accel_step_detector_unit.sv
// Top level of the accelerometer step detector.
// Each transaction on the sample channel carries one three-axis reading or a calibrate
// command, and yields exactly one transaction on the result channel. One item is
// processed at a time: the squares of the three axes are accumulated one multiplier
// bit per cycle, and the square root then produces one bit per cycle, after which
// the evaluation state updates the detection state once the output register is free.
// A finished result waits in an output register, so the next sample is taken while
// it is still unread. Threshold registers accept a write in every cycle and should
// only be changed while no item is in flight.
module accel_step_detector_unit #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = asd_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            smp_valid,
    output logic                            smp_stall,
    input  asd_pkg::smp_item_t              smp_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output asd_pkg::res_item_t              res_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_EVAL
    } state_t;

    state_t                   state_reg;
    logic                     opcode_reg;
    logic                     out_valid_reg;
    asd_pkg::res_item_t       res_reg;
    asd_pkg::cfg_t            cfg_reg;

    logic                     smp_accept;
    logic                     det_apply;
    logic [SAMPLE_BITS-1:0]   raw_x, raw_y, raw_z;
    logic [SAMPLE_BITS-1:0]   abs_x, abs_y, abs_z;
    logic [2*SAMPLE_BITS-1:0] sq_sum;
    logic                     sq_done;
    logic [SAMPLE_BITS-1:0]   rt_root;
    logic                     rt_done;
    asd_pkg::res_item_t       det_res;

    assign smp_stall  = (state_reg != ST_IDLE);
    assign smp_accept = smp_valid && !smp_stall;
    assign det_apply  = (state_reg == ST_EVAL) && (!out_valid_reg || !res_stall);
    assign cfg_ready  = 1'b1;
    assign res_valid  = out_valid_reg;
    assign res_data   = res_reg;

    always_comb
    begin
        raw_x = smp_data.accel_x[SAMPLE_BITS-1:0];
        raw_y = smp_data.accel_y[SAMPLE_BITS-1:0];
        raw_z = smp_data.accel_z[SAMPLE_BITS-1:0];
        abs_x = raw_x[SAMPLE_BITS-1] ? (~raw_x + SAMPLE_BITS'(1)) : raw_x;
        abs_y = raw_y[SAMPLE_BITS-1] ? (~raw_y + SAMPLE_BITS'(1)) : raw_y;
        abs_z = raw_z[SAMPLE_BITS-1] ? (~raw_z + SAMPLE_BITS'(1)) : raw_z;
    end

    asd_sumsq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sumsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (smp_accept),
        .abs_x (abs_x),
        .abs_y (abs_y),
        .abs_z (abs_z),
        .sum   (sq_sum),
        .done  (sq_done)
    );

    asd_isqrt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_done),
        .radicand (sq_sum),
        .root     (rt_root),
        .done     (rt_done)
    );

    asd_detect #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (det_apply),
        .opcode (opcode_reg),
        .mag    (asd_pkg::MAG_W'(rt_root)),
        .cfg    (cfg_reg),
        .res    (det_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_threshold  <= asd_pkg::NOISE_RESET;
            cfg_reg.peak_threshold   <= asd_pkg::PEAK_RESET;
            cfg_reg.valley_threshold <= asd_pkg::VALLEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asd_pkg::CFG_NOISE:  cfg_reg.noise_threshold  <= cfg_data[15:0];
                asd_pkg::CFG_PEAK:   cfg_reg.peak_threshold   <= cfg_data[15:0];
                asd_pkg::CFG_VALLEY: cfg_reg.valley_threshold <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            opcode_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (det_apply)
            begin
                res_reg       <= det_res;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (smp_accept)
                    begin
                        opcode_reg <= smp_data.opcode;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (rt_done)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (det_apply)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        smp_accept |=> state_reg == ST_SQUARE)
        else $error("accepted sample did not start the squaring pass");

    a_square_done: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_SQUARE)
        else $error("squaring finished outside its phase");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        rt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its phase");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_EVAL))
        else $error("result appeared without an evaluation cycle");

endmodule

### design/asd_sumsq.sv
// Bit-serial sum of the squares of three axis magnitudes.
module asd_sumsq #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SAMPLE_BITS-1:0]   abs_x,
    input  logic [SAMPLE_BITS-1:0]   abs_y,
    input  logic [SAMPLE_BITS-1:0]   abs_z,
    output logic [2*SAMPLE_BITS-1:0] sum,
    output logic                     done
);

    localparam int SUM_W = 2 * SAMPLE_BITS;
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    logic [SUM_W-1:0]       mc_x_reg, mc_y_reg, mc_z_reg;
    logic [SAMPLE_BITS-1:0] mp_x_reg, mp_y_reg, mp_z_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [SUM_W-1:0]       acc_next;

    always_comb
    begin
        acc_next = acc_reg
                 + (mp_x_reg[0] ? mc_x_reg : '0)
                 + (mp_y_reg[0] ? mc_y_reg : '0)
                 + (mp_z_reg[0] ? mc_z_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            acc_reg   <= '0;
            mc_x_reg  <= '0;
            mc_y_reg  <= '0;
            mc_z_reg  <= '0;
            mp_x_reg  <= '0;
            mp_y_reg  <= '0;
            mp_z_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= CNT_W'(SAMPLE_BITS);
            acc_reg   <= '0;
            mc_x_reg  <= SUM_W'(abs_x);
            mc_y_reg  <= SUM_W'(abs_y);
            mc_z_reg  <= SUM_W'(abs_z);
            mp_x_reg  <= abs_x;
            mp_y_reg  <= abs_y;
            mp_z_reg  <= abs_z;
        end
        else if (busy_reg)
        begin
            acc_reg   <= acc_next;
            mc_x_reg  <= mc_x_reg << 1;
            mc_y_reg  <= mc_y_reg << 1;
            mc_z_reg  <= mc_z_reg << 1;
            mp_x_reg  <= mp_x_reg >> 1;
            mp_y_reg  <= mp_y_reg >> 1;
            mp_z_reg  <= mp_z_reg >> 1;
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

### design/asd_isqrt.sv
// Digit-by-digit floor square root, one result bit per cycle.
module asd_isqrt #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2*SAMPLE_BITS-1:0] radicand,
    output logic [SAMPLE_BITS-1:0]   root,
    output logic                     done
);

    localparam int RAD_W = 2 * SAMPLE_BITS;
    localparam int REM_W = SAMPLE_BITS + 2;
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    logic [RAD_W-1:0]       rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [SAMPLE_BITS-1:0] root_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [REM_W-1:0]       cand;
    logic [REM_W-1:0]       trial;
    logic                   fits;

    always_comb
    begin
        cand  = {rem_reg[SAMPLE_BITS-1:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial = {root_reg, 2'b01};
        fits  = (cand >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= CNT_W'(SAMPLE_BITS);
            rad_reg   <= radicand;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg   <= rad_reg << 2;
            rem_reg   <= fits ? (cand - trial) : cand;
            root_reg  <= {root_reg[SAMPLE_BITS-2:0], fits};
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### design/asd_detect.sv
// Noise gate, peak and valley tracking, step counting and baseline calibration.
module asd_detect #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = asd_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          apply,
    input  logic                          opcode,
    input  logic [asd_pkg::MAG_W-1:0]     mag,
    input  asd_pkg::cfg_t                 cfg,
    output asd_pkg::res_item_t            res
);

    localparam logic [asd_pkg::MAG_W-1:0] REF_RESET =
        asd_pkg::MAG_W'(1 << (SAMPLE_BITS - 2));

    logic [asd_pkg::MAG_W-1:0]          ref_reg, ref_next;
    logic signed [asd_pkg::LEVEL_W-1:0] prev_reg, prev_next;
    logic [1:0]                         trend_reg, trend_next;
    logic                               valley_reg, valley_next;
    logic                               first_reg, first_next;
    logic [COUNT_BITS-1:0]              steps_reg, steps_next;
    logic [15:0]                        peak_reg, peak_next;

    logic signed [asd_pkg::LEVEL_W-1:0] cur;
    logic [asd_pkg::LEVEL_W:0]          delta;
    logic [asd_pkg::LEVEL_W:0]          diff;
    logic                               below;
    logic                               take;
    logic                               low_valley;
    logic                               high_peak;
    logic                               stepped;

    always_comb
    begin
        cur        = $signed({1'b0, mag} - {1'b0, ref_reg});
        delta      = {cur[asd_pkg::LEVEL_W-1], cur}
                   - {prev_reg[asd_pkg::LEVEL_W-1], prev_reg};
        diff       = delta[asd_pkg::LEVEL_W] ? (~delta + (asd_pkg::LEVEL_W + 1)'(1)) : delta;
        below      = (diff < {2'b00, cfg.noise_threshold});
        take       = !below || first_reg;
        low_valley = (prev_reg < cfg.valley_threshold);
        high_peak  = ($signed({prev_reg[asd_pkg::LEVEL_W-1], prev_reg})
                      > $signed({2'b00, cfg.peak_threshold}));

        ref_next    = ref_reg;
        prev_next   = prev_reg;
        trend_next  = trend_reg;
        valley_next = valley_reg;
        first_next  = first_reg;
        steps_next  = steps_reg;
        peak_next   = peak_reg;
        stepped     = 1'b0;

        if (opcode == asd_pkg::OP_CALIBRATE)
        begin
            ref_next    = mag;
            prev_next   = '0;
            trend_next  = asd_pkg::TREND_NONE;
            valley_next = 1'b0;
            first_next  = 1'b1;
            steps_next  = '0;
            peak_next   = '0;
        end
        else if (take)
        begin
            if (below)
            begin
                first_next = 1'b0;
            end
            if (cur > prev_reg)
            begin
                if (trend_reg == asd_pkg::TREND_FALL && low_valley)
                begin
                    valley_next = 1'b1;
                end
                trend_next = asd_pkg::TREND_RISE;
            end
            else if (cur < prev_reg)
            begin
                if (trend_reg == asd_pkg::TREND_RISE && high_peak && valley_reg)
                begin
                    steps_next  = steps_reg + COUNT_BITS'(1);
                    peak_next   = prev_reg[15:0];
                    valley_next = 1'b0;
                    stepped     = 1'b1;
                end
                trend_next = asd_pkg::TREND_FALL;
            end
            prev_next = cur;
        end

        if (opcode == asd_pkg::OP_CALIBRATE)
        begin
            res = '0;
        end
        else
        begin
            res.relative_magnitude = cur;
            res.sample_accepted    = take;
            res.step_detected      = stepped;
            res.step_total         = 16'(steps_next);
            res.last_peak          = peak_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg    <= REF_RESET;
            prev_reg   <= '0;
            trend_reg  <= asd_pkg::TREND_NONE;
            valley_reg <= 1'b0;
            first_reg  <= 1'b1;
            steps_reg  <= '0;
            peak_reg   <= '0;
        end
        else if (apply)
        begin
            ref_reg    <= ref_next;
            prev_reg   <= prev_next;
            trend_reg  <= trend_next;
            valley_reg <= valley_next;
            first_reg  <= first_next;
            steps_reg  <= steps_next;
            peak_reg   <= peak_next;
        end
    end

endmodule

### bench/accel_step_detector_unit_test.sv
// Self-checking regression of the accelerometer step detector against a built-in step tracker.
module accel_step_detector_unit_test;

    localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int ONE_G = 16384;

    typedef struct {
        logic op;
        int   x;
        int   y;
        int   z;
        bit   typed;
        int   rel;
        bit   acc;
        bit   stp;
        int   total;
        int   peak;
    } directed_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           smp_valid;
    logic                           smp_stall;
    asd_pkg::smp_item_t             smp_data;
    logic                           res_valid;
    logic                           res_stall;
    asd_pkg::res_item_t             res_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [asd_pkg::CFG_W-1:0]      cfg_data;

    int send_idle_pct;
    int stall_pct;
    int cycle_count;
    int mismatches;
    asd_pkg::res_item_t pending_reports[$];

    // Step tracker state and thresholds.
    int         gate_min;
    int         peak_min;
    int         valley_max;
    int         baseline;
    int         last_level;
    logic [1:0] slope;
    bit         armed;
    bit         awaiting_first;
    logic [15:0] step_count;
    logic [15:0] held_peak;

    accel_step_detector_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int floor_root(longint v);
        int     r;
        longint t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r | (1 << b);
            if (t * t <= v)
                r = int'(t);
        end
        return r;
    endfunction

    function automatic void clear_tracking();
        last_level     = 0;
        slope          = asd_pkg::TREND_NONE;
        armed          = 1'b0;
        awaiting_first = 1'b1;
        step_count     = '0;
        held_peak      = '0;
    endfunction

    function automatic asd_pkg::res_item_t predict_report(asd_pkg::smp_item_t it);
        longint             sx;
        longint             sy;
        longint             sz;
        int                 mag;
        int                 lvl;
        int                 delta;
        asd_pkg::res_item_t r;
        sx = it.accel_x;
        sy = it.accel_y;
        sz = it.accel_z;
        mag = floor_root(sx * sx + sy * sy + sz * sz);
        r = '0;
        if (it.opcode == asd_pkg::OP_CALIBRATE)
        begin
            baseline = mag & 16'hFFFF;
            clear_tracking();
            return r;
        end
        lvl = mag - baseline;
        delta = (lvl >= last_level) ? lvl - last_level : last_level - lvl;
        if (delta >= gate_min || awaiting_first)
        begin
            if (delta < gate_min)
                awaiting_first = 1'b0;
            r.sample_accepted = 1'b1;
            if (lvl > last_level)
            begin
                if (slope == asd_pkg::TREND_FALL && last_level < valley_max)
                    armed = 1'b1;
                slope = asd_pkg::TREND_RISE;
            end
            else if (lvl < last_level)
            begin
                if (slope == asd_pkg::TREND_RISE && last_level > peak_min && armed)
                begin
                    step_count = step_count + 16'd1;
                    held_peak = last_level[15:0];
                    armed = 1'b0;
                    r.step_detected = 1'b1;
                end
                slope = asd_pkg::TREND_FALL;
            end
            last_level = lvl;
        end
        r.relative_magnitude = lvl[16:0];
        r.step_total = step_count;
        r.last_peak = held_peak;
        return r;
    endfunction

    function automatic asd_pkg::smp_item_t walk_sample(int lvl);
        asd_pkg::smp_item_t it;
        int                 z;
        z = ONE_G + lvl;
        if (z > 32767)
            z = 32767;
        if (z < -32768)
            z = -32768;
        it.opcode  = asd_pkg::OP_MEASURE;
        it.accel_x = 16'(int'($urandom_range(0, 3000)) - 1500);
        it.accel_y = 16'(int'($urandom_range(0, 3000)) - 1500);
        it.accel_z = 16'(z);
        return it;
    endfunction

    task automatic send_sample(input asd_pkg::smp_item_t it, input bit typed,
                               input asd_pkg::res_item_t want);
        asd_pkg::res_item_t guess;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            smp_valid <= 1'b0;
            @(negedge clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= it;
        do
            @(posedge clk);
        while (smp_stall !== 1'b0);
        guess = predict_report(it);
        pending_reports.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [asd_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 17'(value);
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            asd_pkg::CFG_NOISE:  gate_min = value & 16'hFFFF;
            asd_pkg::CFG_PEAK:   peak_min = value & 16'hFFFF;
            asd_pkg::CFG_VALLEY: valley_max = int'($signed(17'(value)));
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        smp_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        asd_pkg::res_item_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", res_data);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (res_data.relative_magnitude !== want.relative_magnitude
                    || res_data.sample_accepted !== want.sample_accepted
                    || res_data.step_detected !== want.step_detected
                    || res_data.step_total !== want.step_total
                    || res_data.last_peak !== want.last_peak)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected rel %0d acc %0b step %0b total %0d peak %0d",
                                 want.relative_magnitude, want.sample_accepted,
                                 want.step_detected, want.step_total, want.last_peak);
                        $display("          got rel %0d acc %0b step %0b total %0d peak %0d",
                                 res_data.relative_magnitude, res_data.sample_accepted,
                                 res_data.step_detected, res_data.step_total,
                                 res_data.last_peak);
                    end
                end
            end
        end
    end

    initial
    begin
        directed_row_t      rows[22];
        int                 noise_set[5];
        int                 peak_set[5];
        int                 valley_set[5];
        asd_pkg::smp_item_t it;
        asd_pkg::res_item_t want;
        int                 sent;
        int                 depth;
        int                 crest;
        int                 n;
        int                 lvl;
        int                 pick;

        rows = '{
            '{asd_pkg::OP_MEASURE,        0,      0,  16384, 1,     0, 1, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  14384, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  12384, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  16384, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  22384, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  18384, 1,  2000, 1, 1, 1, 6000},
            '{asd_pkg::OP_MEASURE,        0,      0,  18484, 1,  2100, 0, 0, 1, 6000},
            '{asd_pkg::OP_MEASURE,   -32768, -32768, -32768, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,    32767,  32767,  32767, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,       -1,     -1,     -1, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,      0, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_CALIBRATE,      0,      0,      0, 1,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,      0, 1,     0, 1, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,   -32768, -32768, -32768, 1, 56755, 1, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,    32767, -32768,      0, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_CALIBRATE, -32768, -32768, -32768, 1,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,      0, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,    21845, -21846,  32767, 0,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_CALIBRATE,      0,      0,  16384, 1,     0, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  16484, 1,   100, 1, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  16584, 1,   200, 0, 0, 0,    0},
            '{asd_pkg::OP_MEASURE,        0,      0,  17384, 0,     0, 0, 0, 0,    0}
        };
        noise_set  = '{0, 65535, 492, 200, 0};
        peak_set   = '{0, 56756, 4915, 3000, 56756};
        valley_set = '{0, -56756, -492, -1000, 0};

        rst_n         = 1'b0;
        smp_valid     = 1'b0;
        smp_data      = '0;
        res_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        mismatches    = 0;
        gate_min      = 492;
        peak_min      = 4915;
        valley_max    = -492;
        baseline      = ONE_G;
        clear_tracking();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            it.opcode  = rows[i].op;
            it.accel_x = 16'(rows[i].x);
            it.accel_y = 16'(rows[i].y);
            it.accel_z = 16'(rows[i].z);
            want.relative_magnitude = 17'(rows[i].rel);
            want.sample_accepted    = rows[i].acc;
            want.step_detected      = rows[i].stp;
            want.step_total         = 16'(rows[i].total);
            want.last_peak          = 16'(rows[i].peak);
            send_sample(it, rows[i].typed, want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_quiet();
            if (p < 5)
            begin
                write_reg(asd_pkg::CFG_NOISE, noise_set[p]);
                write_reg(asd_pkg::CFG_PEAK, peak_set[p]);
                write_reg(asd_pkg::CFG_VALLEY, valley_set[p]);
            end
            else
            begin
                write_reg(asd_pkg::CFG_NOISE, $urandom_range(0, 1500));
                write_reg(asd_pkg::CFG_PEAK, $urandom_range(0, 12000));
                write_reg(asd_pkg::CFG_VALLEY, -int'($urandom_range(0, 8000)));
            end
            write_reg(CFG_UNUSED, $urandom_range(0, 131071));
            cfg_valid <= 1'b0;
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 67;
                end
                default:
                begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    wait_quiet();
                if (pick < 12)
                begin
                    it.opcode  = 1'($urandom_range(0, 1));
                    it.accel_x = 16'($urandom);
                    it.accel_y = 16'($urandom);
                    it.accel_z = 16'($urandom);
                    send_sample(it, 1'b0, '0);
                    sent++;
                end
                else if (pick < 16)
                begin
                    it = walk_sample(int'($urandom_range(0, 3000)) - 1500);
                    it.opcode = asd_pkg::OP_CALIBRATE;
                    send_sample(it, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    depth = $urandom_range(0, 9000);
                    crest = $urandom_range(0, 20000);
                    n = $urandom_range(1, 4);
                    for (int k = 1; k <= 3 * n; k++)
                    begin
                        if (k <= n)
                            lvl = -depth * k / n;
                        else
                            lvl = -depth + (crest + depth) * (k - n) / (2 * n);
                        lvl += int'($urandom_range(0, 400)) - 200;
                        send_sample(walk_sample(lvl), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        smp_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
